// ===== src/parabola_breakpoint_x_top_defines.svh =====
// assertion macros for the beach-line breakpoint block
// used by parabola_breakpoint_x_top, needs i_clk and i_rst_n in scope
`ifndef PARABOLA_BREAKPOINT_X_TOP_DEFINES_SVH
`define PARABOLA_BREAKPOINT_X_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define PBX_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("pbx assertion failed");
`define PBX_ASSERT_NORST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("pbx reset assertion failed");
`else
`define PBX_ASSERT(lbl, prop)
`define PBX_ASSERT_NORST(lbl, prop)
`endif
`endif

// ===== src/pbx_pkg.sv =====
// types and width constants of the beach-line breakpoint block
// no dependencies
`default_nettype none

package pbx_pkg;

    localparam int CoordW = 32;
    localparam int DiffW  = CoordW + 1;
    localparam int ProdW  = 2 * DiffW;
    localparam int MulXW  = CoordW + DiffW;
    localparam int BW     = MulXW + 1;
    localparam int PW     = 2 * CoordW + 1;
    localparam int SumW   = 2 * CoordW + 2;
    localparam int HalfW  = DiffW;
    localparam int PPW    = 2 * HalfW;
    localparam int MidW   = PPW + 1;
    localparam int RadW   = ((PW + SumW + 1) / 2) * 2;
    localparam int RootW  = RadW / 2;
    localparam int RemW   = RootW + 2;
    localparam int NW     = RootW + 2;
    localparam int AW     = DiffW;
    localparam int QDepth = 4;
    localparam int QAw    = 2;

    typedef enum logic [1:0] {
        KIND_ON_FIRST,
        KIND_ON_SECOND,
        KIND_LEVEL,
        KIND_GENERAL
    } t_kind;

    typedef struct packed {
        logic signed [CoordW-1:0] sweep_y;
        logic signed [CoordW-1:0] first_focus_x;
        logic signed [CoordW-1:0] first_focus_y;
        logic signed [CoordW-1:0] second_focus_x;
        logic signed [CoordW-1:0] second_focus_y;
    } t_in_word;

    typedef struct packed {
        logic signed [CoordW-1:0] break_x;
        logic                     fault_flag;
    } t_out_word;

    typedef struct packed {
        t_kind                    kind;
        logic signed [CoordW-1:0] spec_x;
        logic signed [CoordW-1:0] s;
        logic signed [CoordW-1:0] x1;
        logic signed [CoordW-1:0] y1;
        logic signed [CoordW-1:0] x2;
        logic signed [CoordW-1:0] y2;
    } t_job;

    typedef struct packed {
        t_kind                    kind;
        logic signed [CoordW-1:0] spec_x;
        logic                     aneg;
        logic                     fneg;
        logic [AW-1:0]            amag;
        logic signed [BW-1:0]     b;
    } t_sq_side;

    typedef struct packed {
        t_kind                    kind;
        logic signed [CoordW-1:0] spec_x;
        logic                     rneg;
        logic                     fneg;
        logic                     ovf;
        logic [AW-1:0]            amag;
    } t_dv_side;

    typedef struct packed {
        logic push;
        logic pop;
        logic full;
        logic empty;
    } t_q_stat;

endpackage

`default_nettype wire

// ===== src/pbx_front.sv =====
// front stage: registers an input word and classifies the query
// depends on pbx_pkg
`default_nettype none

module pbx_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pbx_pkg::t_in_word i_in_word,
    output logic             o_in_ready,
    output logic             o_job_valid,
    output pbx_pkg::t_job    o_job,
    input  logic             i_job_ready
);

    localparam int CoordW = pbx_pkg::CoordW;

    logic          r_valid;
    pbx_pkg::t_job r_job;
    pbx_pkg::t_job n_job;
    logic [CoordW:0] mid_sum;

    assign o_in_ready  = !r_valid || i_job_ready;
    assign o_job_valid = r_valid;
    assign o_job       = r_job;

    always_comb begin
        mid_sum = {i_in_word.first_focus_x[CoordW-1], i_in_word.first_focus_x}
                + {i_in_word.second_focus_x[CoordW-1], i_in_word.second_focus_x};
        n_job.s  = i_in_word.sweep_y;
        n_job.x1 = i_in_word.first_focus_x;
        n_job.y1 = i_in_word.first_focus_y;
        n_job.x2 = i_in_word.second_focus_x;
        n_job.y2 = i_in_word.second_focus_y;
        if (i_in_word.sweep_y == i_in_word.first_focus_y) begin
            n_job.kind   = pbx_pkg::KIND_ON_FIRST;
            n_job.spec_x = i_in_word.first_focus_x;
        end else if (i_in_word.sweep_y == i_in_word.second_focus_y) begin
            n_job.kind   = pbx_pkg::KIND_ON_SECOND;
            n_job.spec_x = i_in_word.second_focus_x;
        end else if (i_in_word.first_focus_y == i_in_word.second_focus_y) begin
            n_job.kind   = pbx_pkg::KIND_LEVEL;
            n_job.spec_x = mid_sum[CoordW:1];
        end else begin
            n_job.kind   = pbx_pkg::KIND_GENERAL;
            n_job.spec_x = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/pbx_fifo.sv =====
// short job queue between the front stage and the arithmetic pipeline
// depends on pbx_pkg
`default_nettype none

module pbx_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push_valid,
    input  pbx_pkg::t_job    i_push_job,
    output logic             o_push_ready,
    output logic             o_pop_valid,
    output pbx_pkg::t_job    o_pop_job,
    input  logic             i_pop_ready,
    output pbx_pkg::t_q_stat o_stat
);

    localparam int QDepth = pbx_pkg::QDepth;
    localparam int QAw    = pbx_pkg::QAw;

    pbx_pkg::t_job  r_mem [QDepth];
    logic [QAw-1:0] r_wr;
    logic [QAw-1:0] r_rd;
    logic [QAw:0]   r_cnt;
    logic           full;
    logic           empty;
    logic           push;
    logic           pop;

    assign full  = (r_cnt == (QAw+1)'(QDepth));
    assign empty = (r_cnt == '0);
    assign push  = i_push_valid && !full;
    assign pop   = i_pop_ready && !empty;

    assign o_push_ready = !full;
    assign o_pop_valid  = !empty;
    assign o_pop_job    = r_mem[r_rd];

    assign o_stat.push  = push;
    assign o_stat.pop   = pop;
    assign o_stat.full  = full;
    assign o_stat.empty = empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_push_job;
        end
    end

endmodule

`default_nettype wire

// ===== src/pbx_back.sv =====
// arithmetic pipeline: products, exact square root, division, saturation
// depends on pbx_pkg
`default_nettype none

module pbx_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    input  pbx_pkg::t_job      i_job,
    output logic               o_job_ready,
    output logic               o_out_valid,
    output pbx_pkg::t_out_word o_out_word,
    input  logic               i_out_ready
);

    localparam int CoordW = pbx_pkg::CoordW;
    localparam int DiffW  = pbx_pkg::DiffW;
    localparam int ProdW  = pbx_pkg::ProdW;
    localparam int MulXW  = pbx_pkg::MulXW;
    localparam int BW     = pbx_pkg::BW;
    localparam int PW     = pbx_pkg::PW;
    localparam int SumW   = pbx_pkg::SumW;
    localparam int HalfW  = pbx_pkg::HalfW;
    localparam int PPW    = pbx_pkg::PPW;
    localparam int MidW   = pbx_pkg::MidW;
    localparam int RadW   = pbx_pkg::RadW;
    localparam int RootW  = pbx_pkg::RootW;
    localparam int RemW   = pbx_pkg::RemW;
    localparam int NW     = pbx_pkg::NW;
    localparam int AW     = pbx_pkg::AW;

    logic adv;

    // stage 1: differences
    logic                     r1_v;
    pbx_pkg::t_kind           r1_kind;
    logic signed [CoordW-1:0] r1_spec;
    logic signed [DiffW-1:0]  r1_u1, r1_u2, r1_dx, r1_dy, r1_a;
    logic signed [CoordW-1:0] r1_x1, r1_x2;
    // stage 2: products
    logic                     r2_v;
    pbx_pkg::t_kind           r2_kind;
    logic signed [CoordW-1:0] r2_spec;
    logic signed [ProdW-1:0]  r2_p, r2_dx2, r2_dy2;
    logic signed [MulXW-1:0]  r2_bm1, r2_bm2;
    logic                     r2_aneg;
    logic [AW-1:0]            r2_amag;
    // stage 3: discriminant factors and b
    logic                     r3_v;
    pbx_pkg::t_sq_side        r3_side;
    logic [PW-1:0]            r3_p;
    logic [SumW-1:0]          r3_q;
    // stages 4 to 7: wide product
    logic                     r4_v, r5_v, r6_v, r7_v;
    pbx_pkg::t_sq_side        r4_side, r5_side, r6_side, r7_side;
    logic [PPW-1:0]           r4_ll, r4_lh, r4_hl, r4_hh;
    logic [PPW-1:0]           r5_ll, r5_hh;
    logic [MidW-1:0]          r5_mid;
    logic [RadW-1:0]          r6_lo;
    logic [PPW-1:0]           r6_hh;
    logic [RadW-1:0]          r7_rad;
    // square root stages
    logic                     r_sq_v    [RootW];
    pbx_pkg::t_sq_side        r_sq_side [RootW];
    logic [RadW-1:0]          r_sq_rad  [RootW];
    logic [RemW-1:0]          r_sq_rem  [RootW];
    logic [RootW-1:0]         r_sq_root [RootW];
    // numerator
    logic                     r_n_v, r_m_v, r_d0_v;
    pbx_pkg::t_sq_side        r_n_side;
    logic signed [NW-1:0]     r_n;
    pbx_pkg::t_dv_side        r_m_side, r_d0_side;
    logic [NW-1:0]            r_m_mag;
    logic [AW-1:0]            r_d0_rem;
    logic [CoordW-1:0]        r_d0_low;
    // division stages
    logic                     r_dv_v    [CoordW];
    pbx_pkg::t_dv_side        r_dv_side [CoordW];
    logic [AW-1:0]            r_dv_rem  [CoordW];
    logic [CoordW-1:0]        r_dv_low  [CoordW];
    logic [CoordW-1:0]        r_dv_q    [CoordW];
    // output
    logic                     r_out_valid;
    pbx_pkg::t_out_word       r_out_word;
    pbx_pkg::t_out_word       n_out_word;

    assign adv         = !r_out_valid || i_out_ready;
    assign o_job_ready = adv;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0; r2_v <= 1'b0; r3_v <= 1'b0; r4_v <= 1'b0;
            r5_v <= 1'b0; r6_v <= 1'b0; r7_v <= 1'b0;
            r_n_v <= 1'b0; r_m_v <= 1'b0; r_d0_v <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r1_v <= i_job_valid; r2_v <= r1_v; r3_v <= r2_v; r4_v <= r3_v;
            r5_v <= r4_v; r6_v <= r5_v; r7_v <= r6_v;
            r_n_v  <= r_sq_v[RootW-1];
            r_m_v  <= r_n_v;
            r_d0_v <= r_m_v;
            r_out_valid <= r_dv_v[CoordW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r1_kind <= i_job.kind;
            r1_spec <= i_job.spec_x;
            r1_u1   <= DiffW'(i_job.y1) - DiffW'(i_job.s);
            r1_u2   <= DiffW'(i_job.y2) - DiffW'(i_job.s);
            r1_dx   <= DiffW'(i_job.x1) - DiffW'(i_job.x2);
            r1_dy   <= DiffW'(i_job.y1) - DiffW'(i_job.y2);
            r1_a    <= DiffW'(i_job.y2) - DiffW'(i_job.y1);
            r1_x1   <= i_job.x1;
            r1_x2   <= i_job.x2;

            r2_kind <= r1_kind;
            r2_spec <= r1_spec;
            r2_p    <= r1_u1 * r1_u2;
            r2_dx2  <= r1_dx * r1_dx;
            r2_dy2  <= r1_dy * r1_dy;
            r2_bm1  <= r1_x2 * r1_u1;
            r2_bm2  <= r1_x1 * r1_u2;
            r2_aneg <= r1_a[DiffW-1];
            r2_amag <= r1_a[DiffW-1] ? AW'(DiffW'(0) - r1_a) : AW'(r1_a);

            r3_side.kind   <= r2_kind;
            r3_side.spec_x <= r2_spec;
            r3_side.aneg   <= r2_aneg;
            r3_side.fneg   <= r2_p[ProdW-1];
            r3_side.amag   <= r2_amag;
            r3_side.b      <= BW'(r2_bm1) - BW'(r2_bm2);
            r3_p <= r2_p[ProdW-1] ? '0 : r2_p[PW-1:0];
            r3_q <= $unsigned(r2_dx2) + $unsigned(r2_dy2);

            r4_side <= r3_side;
            r4_ll <= r3_p[HalfW-1:0]  * r3_q[HalfW-1:0];
            r4_lh <= r3_p[HalfW-1:0]  * r3_q[SumW-1:HalfW];
            r4_hl <= r3_p[PW-1:HalfW] * r3_q[HalfW-1:0];
            r4_hh <= r3_p[PW-1:HalfW] * r3_q[SumW-1:HalfW];

            r5_side <= r4_side;
            r5_ll   <= r4_ll;
            r5_hh   <= r4_hh;
            r5_mid  <= MidW'(r4_lh) + MidW'(r4_hl);

            r6_side <= r5_side;
            r6_lo   <= RadW'(r5_ll) + (RadW'(r5_mid) << HalfW);
            r6_hh   <= r5_hh;

            r7_side <= r6_side;
            r7_rad  <= r6_lo + (RadW'(r6_hh) << (2 * HalfW));
        end
    end

    // one root bit per stage
    for (genvar k = 0; k < RootW; k++) begin : g_sq
        logic              in_v;
        pbx_pkg::t_sq_side in_side;
        logic [RadW-1:0]   in_rad;
        logic [RemW-1:0]   in_rem;
        logic [RootW-1:0]  in_root;
        logic [RemW+1:0]   t;
        logic [RemW+1:0]   trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign in_v    = r7_v;
            assign in_side = r7_side;
            assign in_rad  = r7_rad;
            assign in_rem  = '0;
            assign in_root = '0;
        end else begin : g_next
            assign in_v    = r_sq_v[k-1];
            assign in_side = r_sq_side[k-1];
            assign in_rad  = r_sq_rad[k-1];
            assign in_rem  = r_sq_rem[k-1];
            assign in_root = r_sq_root[k-1];
        end

        assign t     = {in_rem, in_rad[RadW-1-2*k -: 2]};
        assign trial = {2'b00, in_root, 2'b01};
        assign ge    = (t >= trial);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k] <= 1'b0;
            end else if (adv) begin
                r_sq_v[k] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_side[k] <= in_side;
                r_sq_rad[k]  <= in_rad;
                r_sq_rem[k]  <= ge ? RemW'(t - trial) : RemW'(t);
                r_sq_root[k] <= {in_root[RootW-2:0], ge};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_n_side <= r_sq_side[RootW-1];
            r_n <= $signed({2'b00, r_sq_root[RootW-1]}) - NW'(r_sq_side[RootW-1].b);

            r_m_side.kind   <= r_n_side.kind;
            r_m_side.spec_x <= r_n_side.spec_x;
            r_m_side.rneg   <= r_n[NW-1] ^ r_n_side.aneg;
            r_m_side.fneg   <= r_n_side.fneg;
            r_m_side.ovf    <= 1'b0;
            r_m_side.amag   <= r_n_side.amag;
            r_m_mag <= r_n[NW-1] ? $unsigned(NW'(0) - r_n) : $unsigned(r_n);

            r_d0_side.kind   <= r_m_side.kind;
            r_d0_side.spec_x <= r_m_side.spec_x;
            r_d0_side.rneg   <= r_m_side.rneg;
            r_d0_side.fneg   <= r_m_side.fneg;
            r_d0_side.amag   <= r_m_side.amag;
            r_d0_side.ovf    <= (r_m_mag[NW-1:CoordW] >=
                                 {(NW-CoordW-AW)'(0), r_m_side.amag});
            r_d0_rem      <= r_m_mag[CoordW+AW-1:CoordW];
            r_d0_low      <= r_m_mag[CoordW-1:0];
        end
    end

    // one quotient bit per stage
    for (genvar j = 0; j < CoordW; j++) begin : g_dv
        logic              in_v;
        pbx_pkg::t_dv_side in_side;
        logic [AW-1:0]     in_rem;
        logic [CoordW-1:0] in_low;
        logic [CoordW-1:0] in_q;
        logic [AW:0]       t;
        logic              ge;

        if (j == 0) begin : g_first
            assign in_v    = r_d0_v;
            assign in_side = r_d0_side;
            assign in_rem  = r_d0_rem;
            assign in_low  = r_d0_low;
            assign in_q    = '0;
        end else begin : g_next
            assign in_v    = r_dv_v[j-1];
            assign in_side = r_dv_side[j-1];
            assign in_rem  = r_dv_rem[j-1];
            assign in_low  = r_dv_low[j-1];
            assign in_q    = r_dv_q[j-1];
        end

        assign t  = {in_rem, in_low[CoordW-1-j]};
        assign ge = (t >= {1'b0, in_side.amag});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dv_v[j] <= 1'b0;
            end else if (adv) begin
                r_dv_v[j] <= in_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_dv_side[j] <= in_side;
                r_dv_low[j]  <= in_low;
                r_dv_rem[j]  <= ge ? AW'(t - {1'b0, in_side.amag}) : t[AW-1:0];
                r_dv_q[j]    <= {in_q[CoordW-2:0], ge};
            end
        end
    end

    always_comb begin
        logic [CoordW-1:0] q;
        pbx_pkg::t_dv_side sd;
        logic              sat;
        logic [CoordW-1:0] val;
        q  = r_dv_q[CoordW-1];
        sd = r_dv_side[CoordW-1];
        if (!sd.rneg) begin
            sat = sd.ovf || q[CoordW-1];
            val = sat ? {1'b0, {(CoordW-1){1'b1}}} : q;
        end else begin
            sat = sd.ovf || (q[CoordW-1] && (|q[CoordW-2:0]));
            val = sat ? {1'b1, {(CoordW-1){1'b0}}} : CoordW'(0) - q;
        end
        if (sd.kind == pbx_pkg::KIND_GENERAL) begin
            n_out_word.break_x    = val;
            n_out_word.fault_flag = sd.fneg || sat;
        end else begin
            n_out_word.break_x    = sd.spec_x;
            n_out_word.fault_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_word <= n_out_word;
        end
    end

endmodule

`default_nettype wire

// ===== src/parabola_breakpoint_x_top.sv =====
// top level of the beach-line breakpoint block: front stage, job queue, pipeline
// depends on pbx_pkg, pbx_front, pbx_fifo, pbx_back and the defines header
//
// input channel: i_in_valid / o_in_ready carry one query word (sweep y and
// two foci, signed fixed point); output channel: o_out_valid / i_out_ready
// carry the breakpoint x and a fault flag, one result word per query, in order
// registers from acceptance to o_out_valid: one front register, one queue slot,
// seven product stages, 66 square-root stages (one root bit each), three
// numerator stages, 32 divider stages (one quotient bit each) and the output
// register
// throughput is one word per cycle; the pipeline advances as a whole whenever
// the output register is empty or being taken
// when the receiver stalls the pipeline holds, the queue fills, then the
// front register, and only then o_in_ready drops
// reset is synchronous, active low, and empties every stage and the queue
`default_nettype none
`include "parabola_breakpoint_x_top_defines.svh"

module parabola_breakpoint_x_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  pbx_pkg::t_in_word  i_in_word,
    output logic               o_in_ready,
    output logic               o_out_valid,
    output pbx_pkg::t_out_word o_out_word,
    input  logic               i_out_ready
);

    logic             front_valid;
    pbx_pkg::t_job    front_job;
    logic             q_ready;
    logic             job_valid;
    pbx_pkg::t_job    job;
    logic             back_ready;
    pbx_pkg::t_q_stat q_stat;

    pbx_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_word   (i_in_word),
        .o_in_ready  (o_in_ready),
        .o_job_valid (front_valid),
        .o_job       (front_job),
        .i_job_ready (q_ready)
    );

    pbx_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (front_valid),
        .i_push_job   (front_job),
        .o_push_ready (q_ready),
        .o_pop_valid  (job_valid),
        .o_pop_job    (job),
        .i_pop_ready  (back_ready),
        .o_stat       (q_stat)
    );

    pbx_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (job_valid),
        .i_job       (job),
        .o_job_ready (back_ready),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word),
        .i_out_ready (i_out_ready)
    );

    `PBX_ASSERT(a_no_pop_unwritten, (q_stat.empty && !q_stat.push) |=> !q_stat.pop)
    `PBX_ASSERT(a_stall_only_full, !o_in_ready |-> q_stat.full)
    `PBX_ASSERT_NORST(a_reset_clears_out, !i_rst_n |=> !o_out_valid)

endmodule

`default_nettype wire
